@@ rtl/gcrf_pkg.sv @@
// ============================================================================
// gcrf_pkg
// Shared types, codes and the default palette of the graphics control
// register file.
// ============================================================================
package gcrf_pkg;

   // transaction kinds
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // register offsets
   localparam logic [3:0] OFS_DIVIDER   = 4'd0;
   localparam logic [3:0] OFS_FLAGS     = 4'd1;
   localparam logic [3:0] OFS_WIDTH_HI  = 4'd3;
   localparam logic [3:0] OFS_WIDTH_LO  = 4'd4;
   localparam logic [3:0] OFS_HEIGHT_HI = 4'd5;
   localparam logic [3:0] OFS_HEIGHT_LO = 4'd6;
   localparam logic [3:0] OFS_PAL_PTR   = 4'd7;
   localparam logic [3:0] OFS_PAL_HI    = 4'd8;
   localparam logic [3:0] OFS_PAL_LO    = 4'd9;
   localparam logic [3:0] OFS_EXT_HI    = 4'd12;
   localparam logic [3:0] OFS_EXT_LO    = 4'd13;
   localparam logic [3:0] OFS_EXT_DATA  = 4'd14;

   // configuration register indexes
   localparam int unsigned   CSR_INDEX_W    = 2;
   localparam logic [1:0]    CSR_TIMING_W   = 2'd0;
   localparam logic [1:0]    CSR_TIMING_H   = 2'd1;

   localparam logic [15:0] TIMING_W_RESET = 16'd256;
   localparam logic [15:0] TIMING_H_RESET = 16'd160;

   // extended address window
   localparam logic [15:0] ADDR_LIMIT = 16'h9FFF;
   localparam logic [15:0] ADDR_CLAMP = 16'h4FFF;

   // flag register bit positions
   localparam int unsigned FLAG_VSYNC  = 7;
   localparam int unsigned FLAG_BB_EN  = 6;
   localparam int unsigned FLAG_BUFSEL = 5;

   // result source held in the read stage
   localparam logic [1:0] SRC_REG    = 2'd0;
   localparam logic [1:0] SRC_PAL_HI = 2'd1;
   localparam logic [1:0] SRC_PAL_LO = 2'd2;
   localparam logic [1:0] SRC_EXT    = 2'd3;

   typedef struct packed {
      logic       rd_en;
      logic       wr_hi;
      logic       wr_lo;
      logic [7:0] data;
   } pal_cmd_type;

   typedef struct packed {
      logic       wr_hi;
      logic       wr_lo;
      logic [7:0] data;
   } ptr_cmd_type;

   function automatic logic [15:0] pal_default(input logic [7:0] idx);
      logic [15:0] word;
      unique case (idx)
         8'd0:    word = 16'h0000;
         8'd1:    word = 16'h005F;
         8'd2:    word = 16'h050F;
         8'd3:    word = 16'h055F;
         8'd4:    word = 16'h500F;
         8'd5:    word = 16'h505F;
         8'd6:    word = 16'h550F;
         8'd7:    word = 16'hAAAF;
         8'd8:    word = 16'h555F;
         8'd9:    word = 16'h00FF;
         8'd10:   word = 16'h0F0F;
         8'd11:   word = 16'h0FFF;
         8'd12:   word = 16'hF00F;
         8'd13:   word = 16'hF0FF;
         8'd14:   word = 16'hFF0F;
         8'd15:   word = 16'hFFFF;
         default: word = 16'h0000;
      endcase
      return word;
   endfunction

endpackage

@@ rtl/graphics_control_register_file_core.sv @@
// ============================================================================
// graphics_control_register_file_core
// Byte-wide register file of a graphics controller: flags, timing, palette,
// extended RAM window and a free-running divider.
// ============================================================================
// Request channel (req_*): one transaction per read, write or divider tick.
// Response channel (rsp_*): exactly one byte per transaction, in order; zero
// for writes and ticks.
// State updates and memory reads are issued at the accepting edge, where the
// palette and extended RAM register their answer; the byte then passes from
// the read stage into the output register, which drives rsp_valid.
// Throughput is one transaction per cycle while the response side keeps up,
// except that a write to either extended pointer byte holds req_ready low
// through IDX_QUOT and IDX_REM while the pointer is reduced to a RAM index (two multiply steps).
// A stalled response holds in the output register while one more transaction
// drains into the read stage; after that req_ready drops.
// Reset restores flags, pointers, divider and timing at once; the palette
// returns to its default colours through per-entry valid bits, so no clearing
// pass is needed. Extended RAM content is undefined until written.
// csr_* writes the timing registers; indexes beyond the second are ignored.
// ============================================================================
module graphics_control_register_file_core #(
   parameter int unsigned PALETTE_DEPTH = 16,
   parameter int unsigned EXT_RAM_DEPTH = 40960
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic [3:0]                       req_reg_offset,
   input  logic [7:0]                       req_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_read_data,
   input  logic                             csr_write_enable,
   input  logic [gcrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_write_data
);

   localparam int unsigned AW = $clog2(EXT_RAM_DEPTH);

   logic        accept, is_read, is_write, out_free, s1_move, index_idle;
   logic [15:0] timing_w_ff, timing_h_ff;
   logic        vsync_ff, bb_en_ff, buf_sel_ff;
   logic [1:0]  fg_ff, bg_ff;
   logic [7:0]  pal_ptr_ff, div_ff;
   logic [15:0] ext_pointer, pal_word;
   logic [AW-1:0] ram_index;
   logic [7:0]  ext_rd_data;
   logic        s1_valid_ff;
   logic [1:0]  s1_src_ff, src_in;
   logic [7:0]  s1_byte_ff, byte_in, rsp_byte;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   gcrf_pkg::pal_cmd_type pal_cmd;
   gcrf_pkg::ptr_cmd_type ptr_cmd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = (!s1_valid_ff || out_free) && index_idle;
   assign accept    = req_valid && req_ready;
   assign is_read   = accept && (req_func == gcrf_pkg::FUNC_READ);
   assign is_write  = accept && (req_func == gcrf_pkg::FUNC_WRITE);

   assign pal_cmd.rd_en = is_read && (req_reg_offset == gcrf_pkg::OFS_PAL_HI ||
                                      req_reg_offset == gcrf_pkg::OFS_PAL_LO);
   assign pal_cmd.wr_hi = is_write && (req_reg_offset == gcrf_pkg::OFS_PAL_HI);
   assign pal_cmd.wr_lo = is_write && (req_reg_offset == gcrf_pkg::OFS_PAL_LO);
   assign pal_cmd.data  = req_write_data;

   assign ptr_cmd.wr_hi = is_write && (req_reg_offset == gcrf_pkg::OFS_EXT_HI);
   assign ptr_cmd.wr_lo = is_write && (req_reg_offset == gcrf_pkg::OFS_EXT_LO);
   assign ptr_cmd.data  = req_write_data;

   gcrf_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .pal_cmd    (pal_cmd),
      .pal_pointer(pal_ptr_ff),
      .pal_word   (pal_word)
   );

   gcrf_ext_addr #(
      .EXT_RAM_DEPTH(EXT_RAM_DEPTH),
      .AW           (AW)
   ) u_ext_addr (
      .clock      (clock),
      .reset      (reset),
      .ptr_cmd    (ptr_cmd),
      .ext_pointer(ext_pointer),
      .ram_index  (ram_index),
      .index_idle (index_idle)
   );

   gcrf_ext_ram #(
      .EXT_RAM_DEPTH(EXT_RAM_DEPTH),
      .AW           (AW)
   ) u_ext_ram (
      .clock  (clock),
      .wr_en  (is_write && (req_reg_offset == gcrf_pkg::OFS_EXT_DATA)),
      .rd_en  (is_read && (req_reg_offset == gcrf_pkg::OFS_EXT_DATA)),
      .addr   (ram_index),
      .wr_data(req_write_data),
      .rd_data(ext_rd_data)
   );

   // register-sourced read byte, taken at acceptance
   always_comb begin
      src_in  = gcrf_pkg::SRC_REG;
      byte_in = 8'h00;
      if (req_func == gcrf_pkg::FUNC_READ) begin
         unique case (req_reg_offset)
            gcrf_pkg::OFS_DIVIDER:   byte_in = div_ff;
            gcrf_pkg::OFS_FLAGS:     byte_in = {vsync_ff, bb_en_ff, buf_sel_ff, 1'b0,
                                                bg_ff, fg_ff};
            gcrf_pkg::OFS_WIDTH_HI:  byte_in = timing_w_ff[15:8];
            gcrf_pkg::OFS_WIDTH_LO:  byte_in = timing_w_ff[7:0];
            gcrf_pkg::OFS_HEIGHT_HI: byte_in = timing_h_ff[15:8];
            gcrf_pkg::OFS_HEIGHT_LO: byte_in = timing_h_ff[7:0];
            gcrf_pkg::OFS_PAL_PTR:   byte_in = pal_ptr_ff;
            gcrf_pkg::OFS_PAL_HI:    src_in  = gcrf_pkg::SRC_PAL_HI;
            gcrf_pkg::OFS_PAL_LO:    src_in  = gcrf_pkg::SRC_PAL_LO;
            gcrf_pkg::OFS_EXT_HI:    byte_in = ext_pointer[15:8];
            gcrf_pkg::OFS_EXT_LO:    byte_in = ext_pointer[7:0];
            gcrf_pkg::OFS_EXT_DATA:  src_in  = gcrf_pkg::SRC_EXT;
            default:                 byte_in = 8'h00;
         endcase
      end
   end

   always_comb begin
      unique case (s1_src_ff)
         gcrf_pkg::SRC_PAL_HI: rsp_byte = pal_word[15:8];
         gcrf_pkg::SRC_PAL_LO: rsp_byte = pal_word[7:0];
         gcrf_pkg::SRC_EXT:    rsp_byte = ext_rd_data;
         default:              rsp_byte = s1_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_w_ff  <= gcrf_pkg::TIMING_W_RESET;
         timing_h_ff  <= gcrf_pkg::TIMING_H_RESET;
         vsync_ff     <= 1'b1;
         bb_en_ff     <= 1'b0;
         buf_sel_ff   <= 1'b0;
         fg_ff        <= '0;
         bg_ff        <= '0;
         pal_ptr_ff   <= '0;
         div_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == gcrf_pkg::CSR_TIMING_W) timing_w_ff <= csr_write_data;
            if (csr_index == gcrf_pkg::CSR_TIMING_H) timing_h_ff <= csr_write_data;
         end
         if (is_write && (req_reg_offset == gcrf_pkg::OFS_FLAGS)) begin
            vsync_ff <= req_write_data[gcrf_pkg::FLAG_VSYNC];
            bb_en_ff <= req_write_data[gcrf_pkg::FLAG_BB_EN];
            // buffer select only moves while the back buffer is being enabled
            if (req_write_data[gcrf_pkg::FLAG_BB_EN]) begin
               buf_sel_ff <= req_write_data[gcrf_pkg::FLAG_BUFSEL];
            end
            fg_ff <= req_write_data[1:0];
            bg_ff <= req_write_data[3:2];
         end
         if (is_write && (req_reg_offset == gcrf_pkg::OFS_PAL_PTR)) begin
            pal_ptr_ff <= req_write_data;
         end
         if (accept && (req_func == gcrf_pkg::FUNC_TICK)) begin
            div_ff <= div_ff + 8'd1;
         end

         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff  <= src_in;
         s1_byte_ff <= byte_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_byte;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

@@ rtl/gcrf_palette.sv @@
// ============================================================================
// gcrf_palette
// Palette word store: synchronous memory with byte writes and one valid bit
// per entry; an entry never written reads as its default colour.
// ============================================================================
module gcrf_palette #(
   parameter int unsigned PALETTE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gcrf_pkg::pal_cmd_type pal_cmd,
   input  logic [7:0]           pal_pointer,
   output logic [15:0]          pal_word
);

   localparam int unsigned IW = $clog2(PALETTE_DEPTH);

   logic [15:0]             mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] valid_ff;
   logic [PALETTE_DEPTH-1:0] valid_in;
   logic [IW-1:0]           mod_lut [256];
   logic [IW-1:0]           entry;
   logic [15:0]             dflt;
   logic [15:0]             rd_word_ff;
   logic                    rd_valid_ff;
   logic [15:0]             rd_dflt_ff;

   // pointer modulo depth as a constant table
   for (genvar i = 0; i < 256; i++) begin : g_mod
      assign mod_lut[i] = IW'(i % PALETTE_DEPTH);
   end

   assign entry = mod_lut[pal_pointer];
   assign dflt  = gcrf_pkg::pal_default(8'(entry));

   always_comb begin
      valid_in = valid_ff;
      if (pal_cmd.wr_hi || pal_cmd.wr_lo) begin
         valid_in[entry] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // untouched half of a fresh entry takes the default colour
   always_ff @(posedge clock) begin
      if (pal_cmd.wr_hi) begin
         mem[entry][15:8] <= pal_cmd.data;
         if (!valid_ff[entry]) begin
            mem[entry][7:0] <= dflt[7:0];
         end
      end
      if (pal_cmd.wr_lo) begin
         mem[entry][7:0] <= pal_cmd.data;
         if (!valid_ff[entry]) begin
            mem[entry][15:8] <= dflt[15:8];
         end
      end
      if (pal_cmd.rd_en) begin
         rd_word_ff  <= mem[entry];
         rd_valid_ff <= valid_ff[entry];
         rd_dflt_ff  <= dflt;
      end
   end

   assign pal_word = rd_valid_ff ? rd_word_ff : rd_dflt_ff;

endmodule

@@ rtl/gcrf_ext_addr.sv @@
// ============================================================================
// gcrf_ext_addr
// Extended address pointer with clamp, and the sequencer that folds it into
// a RAM index (reciprocal multiply, then multiply-subtract with correction).
// ============================================================================
module gcrf_ext_addr #(
   parameter int unsigned EXT_RAM_DEPTH = 40960,
   parameter int unsigned AW            = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gcrf_pkg::ptr_cmd_type ptr_cmd,
   output logic [15:0]           ext_pointer,
   output logic [AW-1:0]         ram_index,
   output logic                  index_idle
);

   localparam logic [1:0]  IDX_IDLE = 2'd0;
   localparam logic [1:0]  IDX_QUOT = 2'd1;
   localparam logic [1:0]  IDX_REM  = 2'd2;

   // floor(2^32 / depth); depth >= 4096 keeps this within 21 bits
   localparam logic [20:0] RECIP = 21'((64'd1 << 32) / EXT_RAM_DEPTH);
   localparam logic [17:0] DEPTH = 18'(EXT_RAM_DEPTH);

   logic [15:0]   ptr_ff, ptr_in, ptr_new;
   logic [1:0]    st_ff, st_in;
   logic [4:0]    quot_ff;
   logic [36:0]   prod;
   logic [17:0]   rem_raw, rem_fix;
   logic [AW-1:0] index_ff;

   always_comb begin
      ptr_new = ptr_cmd.wr_hi ? {ptr_cmd.data, ptr_ff[7:0]} : {ptr_ff[15:8], ptr_cmd.data};
      ptr_in  = ptr_ff;
      if (ptr_cmd.wr_hi || ptr_cmd.wr_lo) begin
         ptr_in = (ptr_new > gcrf_pkg::ADDR_LIMIT) ? gcrf_pkg::ADDR_CLAMP : ptr_new;
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         IDX_IDLE: if (ptr_cmd.wr_hi || ptr_cmd.wr_lo) st_in = IDX_QUOT;
         IDX_QUOT: st_in = IDX_REM;
         IDX_REM:  st_in = IDX_IDLE;
         default:  st_in = IDX_IDLE;
      endcase
   end

   assign prod    = 37'(ptr_ff) * 37'(RECIP);
   // quotient is exact or one short, so one subtract corrects it
   assign rem_raw = 18'(ptr_ff) - 18'(quot_ff) * DEPTH;
   assign rem_fix = (rem_raw >= DEPTH) ? rem_raw - DEPTH : rem_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         st_ff    <= IDX_IDLE;
         index_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         st_ff  <= st_in;
         if (st_ff == IDX_REM) begin
            index_ff <= AW'(rem_fix);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == IDX_QUOT) begin
         quot_ff <= prod[36:32];
      end
   end

   assign ext_pointer = ptr_ff;
   assign ram_index   = index_ff;
   assign index_idle  = (st_ff == IDX_IDLE);

endmodule

@@ rtl/gcrf_ext_ram.sv @@
// ============================================================================
// gcrf_ext_ram
// Single-port byte RAM for extended graphics memory, registered read.
// ============================================================================
module gcrf_ext_ram #(
   parameter int unsigned EXT_RAM_DEPTH = 40960,
   parameter int unsigned AW            = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [EXT_RAM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
